// ----- hw/rtl/itoa_pkg.sv -----
// Shared constants, types and state codes for the integer to decimal ASCII core.
package itoa_pkg;

    // Word geometry
    localparam int WORD_BITS     = 32;
    localparam int IN_BITS       = 32;
    localparam int CHAR_BITS     = 8;
    localparam int DIGIT_BITS    = 4;

    // Decimal digits needed for the largest magnitude 2**WORD_BITS - 1
    localparam int DEC_DIGITS    = ((WORD_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS      = DEC_DIGITS * DIGIT_BITS;

    // Shift-and-add-3 conversion, several bits retired per cycle
    localparam int STEP_BITS     = 4;
    localparam int CONV_STEPS    = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS      = CONV_STEPS * STEP_BITS;
    localparam int ACC_BITS      = BCD_BITS + PAD_BITS;
    localparam int STEP_CNT_BITS = $clog2(CONV_STEPS);
    localparam int PTR_BITS      = $clog2(DEC_DIGITS);

    // ASCII codes
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic convert;
        logic scan;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic emit_last;
    } dp_status_t;

endpackage

// ----- hw/rtl/itoa_ctrl.sv -----
// Sequencing state machine: accept, convert, scan for leading digit, emit characters.
module itoa_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  itoa_pkg::dp_status_t    status,
    output itoa_pkg::ctrl_cmd_t     cmd
);

    itoa_pkg::ctrl_state_t                  state_reg;
    itoa_pkg::ctrl_state_t                  state_next;
    logic [itoa_pkg::STEP_CNT_BITS-1:0]     cnt_reg;
    logic [itoa_pkg::STEP_CNT_BITS-1:0]     cnt_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itoa_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        unique case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cnt_next = '0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = itoa_pkg::ST_CONVERT;
                end
            end
            itoa_pkg::ST_CONVERT:
            begin
                cmd.convert = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == itoa_pkg::STEP_CNT_BITS'(itoa_pkg::CONV_STEPS - 1))
                begin
                    state_next = itoa_pkg::ST_SCAN;
                end
            end
            itoa_pkg::ST_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = itoa_pkg::ST_EMIT;
            end
            itoa_pkg::ST_EMIT:
            begin
                // one character per free output slot
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = itoa_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/itoa_dpath.sv -----
// Datapath: sign handling, binary to BCD conversion, digit pointer and output register.
module itoa_dpath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            signed_mode_we,
    input  logic                            signed_mode_wdata,
    input  logic [itoa_pkg::IN_BITS-1:0]    value_bits,
    input  itoa_pkg::ctrl_cmd_t             cmd,
    output itoa_pkg::dp_status_t            status,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [itoa_pkg::CHAR_BITS-1:0]  text_char,
    output logic                            last_char
);

    logic                                   signed_mode_reg;
    logic [itoa_pkg::ACC_BITS-1:0]          acc_reg;
    logic [itoa_pkg::ACC_BITS-1:0]          acc_next;
    logic                                   neg_reg;
    logic                                   neg_next;
    logic [itoa_pkg::PTR_BITS-1:0]          ptr_reg;
    logic [itoa_pkg::PTR_BITS-1:0]          ptr_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic [itoa_pkg::CHAR_BITS-1:0]         text_char_reg;
    logic [itoa_pkg::CHAR_BITS-1:0]         text_char_next;
    logic                                   last_char_reg;
    logic                                   last_char_next;

    logic [itoa_pkg::WORD_BITS-1:0]         word;
    logic [itoa_pkg::WORD_BITS-1:0]         mag;
    logic                                   word_neg;
    logic [itoa_pkg::PTR_BITS-1:0]          lead;
    logic [itoa_pkg::DIGIT_BITS-1:0]        digit_arr [itoa_pkg::DEC_DIGITS];
    logic [itoa_pkg::DIGIT_BITS-1:0]        cur_digit;
    logic                                   out_free;
    logic                                   emit_last;

    // Shift-and-add-3 over STEP_BITS input bits
    function automatic logic [itoa_pkg::ACC_BITS-1:0] dabble_step(
        input logic [itoa_pkg::ACC_BITS-1:0] acc_in
    );
        logic [itoa_pkg::ACC_BITS-1:0] a;
        a = acc_in;
        for (int b = 0; b < itoa_pkg::STEP_BITS; b++)
        begin
            for (int d = 0; d < itoa_pkg::DEC_DIGITS; d++)
            begin
                if (a[itoa_pkg::PAD_BITS + d*itoa_pkg::DIGIT_BITS +: itoa_pkg::DIGIT_BITS]
                    >= 4'd5)
                begin
                    a[itoa_pkg::PAD_BITS + d*itoa_pkg::DIGIT_BITS +: itoa_pkg::DIGIT_BITS] =
                        a[itoa_pkg::PAD_BITS + d*itoa_pkg::DIGIT_BITS +: itoa_pkg::DIGIT_BITS]
                        + 4'd3;
                end
            end
            a = a << 1;
        end
        return a;
    endfunction

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b1;
        end
        else if (signed_mode_we)
        begin
            signed_mode_reg <= signed_mode_wdata;
        end
    end

    // Input word and magnitude
    assign word     = itoa_pkg::WORD_BITS'(value_bits);
    assign word_neg = signed_mode_reg & word[itoa_pkg::WORD_BITS-1];
    assign mag      = word_neg ? (~word + 1'b1) : word;

    // BCD digit view
    for (genvar g = 0; g < itoa_pkg::DEC_DIGITS; g++)
    begin : g_digits
        assign digit_arr[g] =
            acc_reg[itoa_pkg::PAD_BITS + g*itoa_pkg::DIGIT_BITS +: itoa_pkg::DIGIT_BITS];
    end

    // Leading nonzero digit, zero gives digit 0
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < itoa_pkg::DEC_DIGITS; i++)
        begin
            if (digit_arr[i] != '0)
            begin
                lead = itoa_pkg::PTR_BITS'(i);
            end
        end
    end

    assign cur_digit = digit_arr[ptr_reg];
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_last = !neg_reg && (ptr_reg == '0);

    assign status.out_free  = out_free;
    assign status.emit_last = emit_last;

    // Next values
    always_comb
    begin
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        ptr_next       = ptr_reg;
        text_char_next = text_char_reg;
        last_char_next = last_char_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.load)
        begin
            acc_next = {{itoa_pkg::BCD_BITS{1'b0}}, itoa_pkg::PAD_BITS'(mag)};
            neg_next = word_neg;
        end
        if (cmd.convert)
        begin
            acc_next = dabble_step(acc_reg);
        end
        if (cmd.scan)
        begin
            ptr_next = lead;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            last_char_next = emit_last;
            if (neg_reg)
            begin
                // sign goes out first
                text_char_next = itoa_pkg::CHAR_MINUS;
                neg_next       = 1'b0;
            end
            else
            begin
                text_char_next = itoa_pkg::CHAR_ZERO
                               + {{(itoa_pkg::CHAR_BITS - itoa_pkg::DIGIT_BITS){1'b0}},
                                  cur_digit};
                ptr_next       = ptr_reg - 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        neg_reg       <= neg_next;
        ptr_reg       <= ptr_next;
        text_char_reg <= text_char_next;
        last_char_reg <= last_char_next;
    end

    assign out_valid = out_valid_reg;
    assign text_char = text_char_reg;
    assign last_char = last_char_reg;

endmodule

// ----- hw/rtl/integer_to_decimal_ascii_core.sv -----
// Top level of the integer to decimal ASCII core: controller plus datapath.
//
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid/in_stall    value_bits[31:0]
//  output    out        out_valid/out_stall  text_char[7:0], last_char
//  config    in         signed_mode_we       signed_mode_wdata
//
// One transaction in is accepted in ST_IDLE, then the shift-and-add-3 converter retires 4 bits
// a cycle in ST_CONVERT, ST_SCAN finds the leading digit, and the output register takes one
// character a cycle while the output is not stalled. The character count runs from 1 to 11
// (a minus sign and ten digits at most).
// Reset is asynchronous, active low; signed_mode comes up as 1 (two's complement).
// A stall on the output holds the character register and pauses emission; the next
// transaction is taken as soon as the last character sits in the output register.
module integer_to_decimal_ascii_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            signed_mode_we,
    input  logic                            signed_mode_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [itoa_pkg::IN_BITS-1:0]    value_bits,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [itoa_pkg::CHAR_BITS-1:0]  text_char,
    output logic                            last_char
);

    itoa_pkg::ctrl_cmd_t    cmd;
    itoa_pkg::dp_status_t   status;

    // Sequencer
    itoa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    itoa_dpath u_dpath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .signed_mode_we    (signed_mode_we),
        .signed_mode_wdata (signed_mode_wdata),
        .value_bits        (value_bits),
        .cmd               (cmd),
        .status            (status),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .text_char         (text_char),
        .last_char         (last_char)
    );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for integer_to_decimal_ascii_core: corner and random words in both readings.
module testbench;
    import itoa_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 30;
    localparam int RANDOM_SEGMENTS = 6;
    localparam int SEGMENT_VALUES  = 32;
    localparam bit READ_UNSIGNED   = 1'b0;
    localparam bit READ_SIGNED     = 1'b1;

    typedef struct packed {
        logic [CHAR_BITS-1:0] code;
        logic                 last;
    } decimal_char_t;

    // Expected characters of accepted words, checked in order
    class text_scoreboard;
        bit            signed_reading;
        decimal_char_t pending_chars[$];
        int            values_seen;
        int            negatives_seen;
        int            chars_seen;
        int            mismatches;

        function new();
            signed_reading = READ_SIGNED;
            values_seen    = 0;
            negatives_seen = 0;
            chars_seen     = 0;
            mismatches     = 0;
        endfunction

        // Decimal text of one accepted word, most significant character first
        function void note_value(logic [IN_BITS-1:0] raw);
            logic [WORD_BITS-1:0] word;
            logic [WORD_BITS-1:0] mag;
            decimal_char_t        text[$];
            decimal_char_t        item;
            bit                   negative;
            word     = raw[WORD_BITS-1:0];
            negative = signed_reading && word[WORD_BITS-1];
            // most negative word negates to itself, read as unsigned magnitude
            mag      = negative ? (~word + 1'b1) : word;
            do
            begin
                item.code = CHAR_ZERO + CHAR_BITS'(mag % 10);
                item.last = 1'b0;
                text.push_front(item);
                mag = mag / 10;
            end
            while (mag != 0);
            if (negative)
            begin
                item.code = CHAR_MINUS;
                item.last = 1'b0;
                text.push_front(item);
                negatives_seen++;
            end
            text[text.size()-1].last = 1'b1;
            foreach (text[k])
                pending_chars.push_back(text[k]);
            values_seen++;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        // One output transaction against the oldest expectation
        task check_char(logic [CHAR_BITS-1:0] code, logic last);
            decimal_char_t want;
            if (pending_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b", code, last));
                return;
            end
            want = pending_chars.pop_front();
            chars_seen++;
            if (code !== want.code)
                report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
                                          code, want.code));
            if (last !== want.last)
                report_mismatch($sformatf("last_char %0b, expected %0b on 0x%02h",
                                          last, want.last, want.code));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n             = 1'b0;
    logic                 signed_mode_we    = 1'b0;
    logic                 signed_mode_wdata = 1'b0;
    logic                 in_valid          = 1'b0;
    logic                 in_stall;
    logic [IN_BITS-1:0]   value_bits        = '0;
    logic                 out_valid;
    logic                 out_stall         = 1'b0;
    logic [CHAR_BITS-1:0] text_char;
    logic                 last_char;

    text_scoreboard       board;
    bit                   in_fire;
    bit                   out_fire;
    logic [CHAR_BITS-1:0] out_code;
    logic                 out_last;
    int                   gap_pct   = 25;
    int                   stall_pct = 25;
    int                   stall_left;
    int                   quiet_cycles;

    logic [IN_BITS-1:0] unsigned_corners [6] = '{
        32'd0, 32'd9, 32'd10, 32'd4000000000, 32'hFFFF_FFFF, 32'h8000_0000
    };
    logic [IN_BITS-1:0] signed_corners [14] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFF6,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
        32'hAAAA_AAAA, 32'h5555_5555
    };

    integer_to_decimal_ascii_core DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .signed_mode_we    (signed_mode_we),
        .signed_mode_wdata (signed_mode_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .value_bits        (value_bits),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .text_char         (text_char),
        .last_char         (last_char)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Handshakes sampled mid-cycle, acted on at the next rising edge
    always @(negedge clk)
    begin
        in_fire  <= rst_n && in_valid && !in_stall;
        out_fire <= rst_n && out_valid && !out_stall;
        out_code <= text_char;
        out_last <= last_char;
    end

    // Receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 10);
        end
        else
            out_stall <= 1'b0;
    end

    // Output check and watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (out_fire)
            board.check_char(out_code, out_last);
        if (in_fire || out_fire || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d characters outstanding",
                     quiet_cycles, board.pending_chars.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // One input transaction, optionally after a random gap
    task automatic send_value(input logic [IN_BITS-1:0] word);
        int unsigned gap;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid   <= 1'b0;
            value_bits <= $urandom;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        value_bits <= word;
        do
            @(posedge clk);
        while (!in_fire);
        board.note_value(word);
    endtask

    // Hold the sender until every expected character has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_chars.size() != 0);
    endtask

    // Register write, only with the core idle
    task automatic write_mode(input bit reading);
        signed_mode_we    <= 1'b1;
        signed_mode_wdata <= reading;
        @(posedge clk);
        signed_mode_we    <= 1'b0;
        board.signed_reading = reading;
    endtask

    // Mix of full-range words, small values, powers of ten and edge words
    function automatic logic [IN_BITS-1:0] pick_value();
        int unsigned        kind;
        logic [IN_BITS-1:0] scale;
        kind  = $urandom_range(0, 7);
        scale = 1;
        case (kind)
            0, 1, 2: return $urandom;
            3:       return $urandom_range(0, 999);
            4:       return 32'd0 - $urandom_range(1, 999);
            5:
            begin
                repeat ($urandom_range(0, 9)) scale = scale * 10;
                return scale + $urandom_range(0, 2) - 1;
            end
            6:       return {1'b1, 31'($urandom_range(0, 15))};
            default: return 32'hFFFF_FFFF - $urandom_range(0, 15);
        endcase
    endfunction

    initial
    begin
        board = new();
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        @(posedge clk);

        // Directed corners, unsigned then two's complement
        write_mode(READ_UNSIGNED);
        foreach (unsigned_corners[k])
            send_value(unsigned_corners[k]);
        wait_drained();
        write_mode(READ_SIGNED);
        foreach (signed_corners[k])
            send_value(signed_corners[k]);
        wait_drained();

        // Random segments, alternating reading and idling mix; last one runs flat out
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            case (seg)
                0:       begin gap_pct <= 20; stall_pct <= 20; end
                1:       begin gap_pct <= 0;  stall_pct <= 40; end
                2:       begin gap_pct <= 40; stall_pct <= 0;  end
                3:       begin gap_pct <= 10; stall_pct <= 10; end
                4:       begin gap_pct <= 30; stall_pct <= 30; end
                default: begin gap_pct <= 0;  stall_pct <= 0;  end
            endcase
            write_mode(seg[0] ? READ_SIGNED : READ_UNSIGNED);
            for (int k = 0; k < SEGMENT_VALUES; k++)
            begin
                send_value(pick_value());
                if (seg == 2 && k == SEGMENT_VALUES / 2)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Summary: %0d words converted (%0d negative), %0d characters checked",
                 board.values_seen, board.negatives_seen, board.chars_seen);
        $display("Both readings exercised, with and without idling on either side");
        if (board.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- integer_to_decimal_ascii_core.f -----
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_ctrl.sv
hw/rtl/itoa_dpath.sv
hw/rtl/integer_to_decimal_ascii_core.sv
verif/testbench.sv
